>>> hdl/rdcm_pkg.sv
// Package of the radial distortion coordinate map: widths, register indexes,
// the configuration record and the number of pipeline stages. No dependencies.
`default_nettype none

package rdcm_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;

  localparam int IN_W   = 12;
  localparam int CTR_W  = 16;
  localparam int COEF_W = 20;
  localparam int RCP_W  = 32;
  localparam int HALF_W = RCP_W / 2;
  localparam int OUT_W  = 20;
  localparam int Q_SH   = 16;

  localparam int POS_W  = COORD_BITS + FRAC_BITS;
  localparam int OFF_W  = ((POS_W > CTR_W) ? POS_W : CTR_W) + 1;
  localparam int SQ_W   = 2 * OFF_W - 1;
  localparam int S_W    = SQ_W + 1;
  localparam int PH_W   = S_W + HALF_W;
  localparam int RSH    = 8 + 2 * FRAC_BITS;
  localparam int R2_W   = 18;
  localparam int R4F_W  = 2 * R2_W;
  localparam int R4_W   = R4F_W - Q_SH;
  localparam int T1_W   = COEF_W + R2_W + 1;
  localparam int T2_W   = COEF_W + R4_W + 1;
  localparam int T2S_W  = T2_W - Q_SH;
  localparam int P_W    = T2S_W + 1;
  localparam int PR_W   = OFF_W + P_W;
  localparam int V_W    = PR_W - Q_SH + 1;

  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  localparam int RAD_STG  = 4;
  localparam int AXIS_STG = 5;
  localparam int NSTG     = RAD_STG + AXIS_STG;

  localparam logic signed [COEF_W-1:0] K0_RESET = COEF_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_COEF_ZERO    = 3'd2,
    REG_COEF_R2      = 3'd3,
    REG_COEF_R4      = 3'd4,
    REG_RECIP_NORM_X = 3'd5,
    REG_RECIP_NORM_Y = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CTR_W-1:0]         center_x;
    logic [CTR_W-1:0]         center_y;
    logic signed [COEF_W-1:0] coef_zero;
    logic signed [COEF_W-1:0] coef_r2;
    logic signed [COEF_W-1:0] coef_r4;
    logic [RCP_W-1:0]         recip_norm_x;
    logic [RCP_W-1:0]         recip_norm_y;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/rdcm_ifs.sv
// Channel interfaces of the radial distortion coordinate map: pixel input,
// source result and configuration write. Depends on rdcm_pkg.
`default_nettype none

interface rdcm_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rdcm_pkg::IN_W-1:0]  pixel_col;
  logic [rdcm_pkg::IN_W-1:0]  pixel_row;
  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface rdcm_src_if;
  logic                              valid;
  logic                              ready;
  logic signed [rdcm_pkg::OUT_W-1:0] source_col;
  logic signed [rdcm_pkg::OUT_W-1:0] source_row;
  logic                              saturated;
  modport source (output valid, output source_col, output source_row, output saturated,
                  input ready);
  modport sink (input valid, input source_col, input source_row, input saturated,
                output ready);
endinterface

interface rdcm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rdcm_pkg::IDX_W-1:0]   index;
  logic [rdcm_pkg::DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/radial_distortion_coordinate_map.sv
// Top level of the radial distortion coordinate map: configuration registers,
// radius front end and one mapping pipeline per axis. Depends on rdcm_pkg,
// the channel interfaces, rdcm_cfg_regs, rdcm_radius and rdcm_axis.
//
//   channel  | interface   | word
//   in_if    | rdcm_pix_if | pixel_col, pixel_row
//   out_if   | rdcm_src_if | source_col, source_row, saturated
//   cfg_if   | rdcm_cfg_if | index, data
//
// A word passes nine register stages, the last of which is the output register;
// one word can enter every cycle while the stages do not hold. All
// nine stages advance together; they hold when the last stage carries a word
// that the sink does not take. Reset clears the stage valid bits and loads
// the register defaults.
`default_nettype none

module radial_distortion_coordinate_map (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rdcm_pix_if.sink   in_if,
  rdcm_src_if.source out_if,
  rdcm_cfg_if.sink   cfg_if
);
  import rdcm_pkg::*;

  cfg_t                    cfg;
  logic                    en;
  logic [NSTG-1:0]         vld_r, vld_nxt;
  logic signed [OFF_W-1:0] dx, dy;
  logic [R2_W-1:0]         r2x, r2y;
  logic                    clip_x, clip_y;

  rdcm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  assign en          = !vld_r[NSTG-1] || out_if.ready;
  assign in_if.ready = en;
  assign vld_nxt     = en ? {vld_r[NSTG-2:0], in_if.valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  rdcm_radius u_radius (
    .clk       (clk),
    .en        (en),
    .cfg       (cfg),
    .pixel_col (in_if.pixel_col),
    .pixel_row (in_if.pixel_row),
    .dx        (dx),
    .dy        (dy),
    .r2x       (r2x),
    .r2y       (r2y)
  );

  rdcm_axis u_axis_x (
    .clk       (clk),
    .en        (en),
    .center    (cfg.center_x),
    .coef_zero (cfg.coef_zero),
    .coef_r2   (cfg.coef_r2),
    .coef_r4   (cfg.coef_r4),
    .off       (dx),
    .r2        (r2x),
    .coord     (out_if.source_col),
    .clip      (clip_x)
  );

  rdcm_axis u_axis_y (
    .clk       (clk),
    .en        (en),
    .center    (cfg.center_y),
    .coef_zero (cfg.coef_zero),
    .coef_r2   (cfg.coef_r2),
    .coef_r4   (cfg.coef_r4),
    .off       (dy),
    .r2        (r2y),
    .coord     (out_if.source_row),
    .clip      (clip_y)
  );

  assign out_if.valid     = vld_r[NSTG-1];
  assign out_if.saturated = clip_x | clip_y;

endmodule

`default_nettype wire

>>> hdl/rdcm_cfg_regs.sv
// Configuration register file of the radial distortion coordinate map.
// Depends on rdcm_pkg and rdcm_cfg_if.
`default_nettype none

module rdcm_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst_n,
  rdcm_cfg_if.sink       cfg_if,
  output rdcm_pkg::cfg_t cfg
);
  import rdcm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_CENTER_X:     cfg_nxt.center_x     = cfg_if.data[CTR_W-1:0];
        REG_CENTER_Y:     cfg_nxt.center_y     = cfg_if.data[CTR_W-1:0];
        REG_COEF_ZERO:    cfg_nxt.coef_zero    = cfg_if.data[COEF_W-1:0];
        REG_COEF_R2:      cfg_nxt.coef_r2      = cfg_if.data[COEF_W-1:0];
        REG_COEF_R4:      cfg_nxt.coef_r4      = cfg_if.data[COEF_W-1:0];
        REG_RECIP_NORM_X: cfg_nxt.recip_norm_x = cfg_if.data[RCP_W-1:0];
        REG_RECIP_NORM_Y: cfg_nxt.recip_norm_y = cfg_if.data[RCP_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x     <= '0;
      cfg_r.center_y     <= '0;
      cfg_r.coef_zero    <= K0_RESET;
      cfg_r.coef_r2      <= '0;
      cfg_r.coef_r4      <= '0;
      cfg_r.recip_norm_x <= '0;
      cfg_r.recip_norm_y <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rdcm_radius.sv
// Radius front end: center offsets, squared distance and the normalized
// squared radius of each axis, in four register stages. Depends on rdcm_pkg.
`default_nettype none

module rdcm_radius (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire rdcm_pkg::cfg_t                cfg,
  input  wire logic [rdcm_pkg::IN_W-1:0]     pixel_col,
  input  wire logic [rdcm_pkg::IN_W-1:0]     pixel_row,
  output logic signed [rdcm_pkg::OFF_W-1:0]  dx,
  output logic signed [rdcm_pkg::OFF_W-1:0]  dy,
  output logic [rdcm_pkg::R2_W-1:0]          r2x,
  output logic [rdcm_pkg::R2_W-1:0]          r2y
);
  import rdcm_pkg::*;

  localparam logic [IN_W-1:0] CMASK = IN_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [R2_W-1:0] R2_MAX = '1;

  logic [POS_W-1:0]          col, row;
  logic signed [OFF_W-1:0]   dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic signed [2*OFF_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic signed [OFF_W-1:0]   dx2_r, dy2_r, dx3_r, dy3_r, dx4_r, dy4_r;
  logic [S_W-1:0]            s;
  logic [PH_W-1:0]           phx_nxt, plx_nxt, phy_nxt, ply_nxt;
  logic [PH_W-1:0]           phx_r, plx_r, phy_r, ply_r;
  logic [PH_W-1:0]           accx, accy, shx, shy;
  logic [R2_W-1:0]           r2x_r, r2y_r, r2x_nxt, r2y_nxt;

  always_comb begin
    col = POS_W'(pixel_col & CMASK) << FRAC_BITS;
    row = POS_W'(pixel_row & CMASK) << FRAC_BITS;
    dx1_nxt = $signed(OFF_W'(col)) - $signed(OFF_W'(cfg.center_x));
    dy1_nxt = $signed(OFF_W'(row)) - $signed(OFF_W'(cfg.center_y));
  end

  assign sqx_full = (2*OFF_W)'(dx1_r) * (2*OFF_W)'(dx1_r);
  assign sqy_full = (2*OFF_W)'(dy1_r) * (2*OFF_W)'(dy1_r);

  always_comb begin
    s = S_W'(sqx_r) + S_W'(sqy_r);
    phx_nxt = PH_W'(s) * PH_W'(cfg.recip_norm_x[RCP_W-1:HALF_W]);
    plx_nxt = PH_W'(s) * PH_W'(cfg.recip_norm_x[HALF_W-1:0]);
    phy_nxt = PH_W'(s) * PH_W'(cfg.recip_norm_y[RCP_W-1:HALF_W]);
    ply_nxt = PH_W'(s) * PH_W'(cfg.recip_norm_y[HALF_W-1:0]);
  end

  always_comb begin
    accx = phx_r + (plx_r >> HALF_W);
    accy = phy_r + (ply_r >> HALF_W);
    shx  = accx >> RSH;
    shy  = accy >> RSH;
    r2x_nxt = (|shx[PH_W-1:R2_W]) ? R2_MAX : shx[R2_W-1:0];
    r2y_nxt = (|shy[PH_W-1:R2_W]) ? R2_MAX : shy[R2_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= dx1_nxt;
      dy1_r <= dy1_nxt;
      sqx_r <= sqx_full[SQ_W-1:0];
      sqy_r <= sqy_full[SQ_W-1:0];
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      phx_r <= phx_nxt;
      plx_r <= plx_nxt;
      phy_r <= phy_nxt;
      ply_r <= ply_nxt;
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      r2x_r <= r2x_nxt;
      r2y_r <= r2y_nxt;
      dx4_r <= dx3_r;
      dy4_r <= dy3_r;
    end
  end

  assign dx  = dx4_r;
  assign dy  = dy4_r;
  assign r2x = r2x_r;
  assign r2y = r2y_r;

endmodule

`default_nettype wire

>>> hdl/rdcm_axis.sv
// One axis of the map: polynomial factor from the normalized squared radius,
// scaling of the offset, recentering and saturation in five stages.
// Depends on rdcm_pkg.
`default_nettype none

module rdcm_axis (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [rdcm_pkg::CTR_W-1:0]          center,
  input  wire logic signed [rdcm_pkg::COEF_W-1:0]  coef_zero,
  input  wire logic signed [rdcm_pkg::COEF_W-1:0]  coef_r2,
  input  wire logic signed [rdcm_pkg::COEF_W-1:0]  coef_r4,
  input  wire logic signed [rdcm_pkg::OFF_W-1:0]   off,
  input  wire logic [rdcm_pkg::R2_W-1:0]           r2,
  output logic signed [rdcm_pkg::OUT_W-1:0]        coord,
  output logic                                     clip
);
  import rdcm_pkg::*;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [R4F_W-1:0]        r4f_r, r4f_nxt;
  logic signed [T1_W-1:0]  t1_r, t1_nxt;
  logic signed [T1_W-Q_SH-1:0] t1s_r;
  logic signed [T2_W-1:0]  t2_r, t2_nxt;
  logic signed [P_W-1:0]   p_r, p_nxt;
  logic signed [PR_W-1:0]  prod_r, prod_nxt;
  logic signed [OFF_W-1:0] off5_r, off6_r, off7_r;
  logic signed [V_W-1:0]   v;
  logic signed [OUT_W-1:0] coord_r, coord_nxt;
  logic                    clip_r, clip_nxt;

  always_comb begin
    r4f_nxt = R4F_W'(r2) * R4F_W'(r2);
    t1_nxt  = T1_W'(coef_r2) * T1_W'($signed({1'b0, r2}));
  end

  assign t2_nxt = T2_W'(coef_r4) * T2_W'($signed({1'b0, r4f_r[R4F_W-1:Q_SH]}));

  always_comb begin
    p_nxt = P_W'(coef_zero) + P_W'(t1s_r) + P_W'($signed(t2_r[T2_W-1:Q_SH]));
  end

  assign prod_nxt = PR_W'(off7_r) * PR_W'(p_r);

  always_comb begin
    v = $signed(V_W'(center)) + V_W'($signed(prod_r[PR_W-1:Q_SH]));
    coord_nxt = v[OUT_W-1:0];
    clip_nxt  = 1'b0;
    if (v[V_W-1:OUT_W-1] != {(V_W-OUT_W+1){v[V_W-1]}}) begin
      clip_nxt  = 1'b1;
      coord_nxt = v[V_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4f_r   <= r4f_nxt;
      t1_r    <= t1_nxt;
      off5_r  <= off;
      t2_r    <= t2_nxt;
      t1s_r   <= t1_r[T1_W-1:Q_SH];
      off6_r  <= off5_r;
      p_r     <= p_nxt;
      off7_r  <= off6_r;
      prod_r  <= prod_nxt;
      coord_r <= coord_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign coord = coord_r;
  assign clip  = clip_r;

endmodule

`default_nettype wire

>>> verif/tb_radial_distortion_coordinate_map.sv
`timescale 1ns / 1ps
// Self-checking bench for radial_distortion_coordinate_map: a directed table, then random
// configurations and pixel words, each result word checked against its table word or a fixed-point predictor.
// Depends on rdcm_pkg, the channel interfaces and the block's RTL.

module tb_radial_distortion_coordinate_map;
  import rdcm_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DIRECTED_ROWS   = 53;
  localparam longint TIMEOUT_NS  = 4_000_000;

  localparam int     QF         = 16;
  localparam int     NORM_SHIFT = 8 + 2 * FRAC_BITS;
  localparam longint R2_CEIL    = (longint'(1) << 18) - 1;
  localparam longint OUT_LO     = -(longint'(1) << (OUT_W - 1));
  localparam longint OUT_HI     = (longint'(1) << (OUT_W - 1)) - 1;

  localparam logic signed [COEF_W-1:0] UNITY_Q16  = 20'sh10000;
  localparam logic [IDX_W-1:0]         REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [OUT_W-1:0] col;
    logic signed [OUT_W-1:0] row;
    logic                    sat;
  } src_word_t;

  typedef enum bit { ROW_PIX, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic [IN_W-1:0]   col;
    logic [IN_W-1:0]   row;
    bit                typed;
    src_word_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rdcm_pix_if pix_ch ();
  rdcm_src_if src_ch ();
  rdcm_cfg_if cfg_ch ();

  radial_distortion_coordinate_map dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_ch),
    .out_if (src_ch),
    .cfg_if (cfg_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  cfg_t      shadow_regs;
  src_word_t pending_src[$];
  src_word_t want_now;
  int        mismatches = 0;
  int        src_idle_rate = 0;
  int        sink_stall_rate = 0;
  int        stall_left = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd0, 12'd0, 1'b1, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b1, '{20'sd65520, 20'sd65520, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd0, 1'b1, '{20'sd65520, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd0, 12'd4095, 1'b1, '{20'sd0, 20'sd65520, 1'b0}},
    '{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b1, '{20'sd65520, 20'sd65520, 1'b0}},
    '{ROW_CFG, REG_CENTER_X, 32'h0000_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_CENTER_Y, 32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd0, 12'd0, 1'b1, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b1, '{20'sd65520, 20'sd65520, 1'b0}},
    '{ROW_CFG, REG_CENTER_X, 32'h0, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_CENTER_Y, 32'h0, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_ZERO, 32'h0007_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_ZERO, 32'hFFF8_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b1,
      '{-20'sd524160, -20'sd524160, 1'b0}},
    '{ROW_CFG, REG_COEF_ZERO, 32'h0001_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R2, 32'h0007_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_RECIP_NORM_X, 32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd2048, 12'd1000, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R2, 32'hFFF8_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R4, 32'h0008_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd0, 12'd0, 1'b1, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_ZERO, 32'h0007_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R2, 32'h0007_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R4, 32'h0007_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_RECIP_NORM_Y, 32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd0, 1'b1, '{20'sd524287, 20'sd0, 1'b1}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd0, 12'd4095, 1'b1, '{20'sd0, 20'sd524287, 1'b1}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd4095, 1'b1,
      '{20'sd524287, 20'sd524287, 1'b1}},
    '{ROW_CFG, REG_COEF_ZERO, 32'h0008_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R2, 32'h0008_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R4, 32'h0008_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd0, 1'b1, '{20'sh80000, 20'sd0, 1'b1}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd10, 12'd3000, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_CENTER_X, 32'h0000_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_CENTER_Y, 32'h0000_FFFF, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_CENTER_X, 32'h0000_8000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_CENTER_Y, 32'h0000_6000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_ZERO, 32'h0001_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R2, 32'hFFFF_E666, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_COEF_R4, 32'h0000_051F, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_RECIP_NORM_X, 32'h0004_0000, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_RECIP_NORM_Y, 32'h0007_1C71, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd4095, 12'd3071, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd2048, 12'd1536, 1'b1,
      '{20'sd32768, 20'sd24576, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd1000, 12'd2500, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_RECIP_NORM_X, 32'h0, 12'd0, 12'd0, 1'b0, '{20'sd0, 20'sd0, 1'b0}},
    '{ROW_PIX, REG_CENTER_X, 32'h0, 12'd1000, 12'd2500, 1'b0, '{20'sd0, 20'sd0, 1'b0}}
  };

  function automatic longint norm_radius_sq(longint dist_sq, logic [31:0] recip);
    longint acc;
    longint r2;
    acc = dist_sq * longint'(recip[31:16]) + ((dist_sq * longint'(recip[15:0])) >>> QF);
    r2 = acc >>> NORM_SHIFT;
    if (r2 > R2_CEIL) begin
      r2 = R2_CEIL;
    end
    return r2;
  endfunction

  function automatic logic signed [OUT_W-1:0] axis_source(longint ctr, longint off, longint r2,
                                                          inout bit clip);
    longint r4;
    longint factor;
    longint pos;
    r4 = (r2 * r2) >>> QF;
    factor = longint'($signed(shadow_regs.coef_zero))
           + ((longint'($signed(shadow_regs.coef_r2)) * r2) >>> QF)
           + ((longint'($signed(shadow_regs.coef_r4)) * r4) >>> QF);
    pos = ctr + ((off * factor) >>> QF);
    if (pos < OUT_LO) begin
      clip = 1'b1;
      pos = OUT_LO;
    end else if (pos > OUT_HI) begin
      clip = 1'b1;
      pos = OUT_HI;
    end
    return pos[OUT_W-1:0];
  endfunction

  function automatic src_word_t predict_source(logic [IN_W-1:0] col, logic [IN_W-1:0] row);
    longint    dx;
    longint    dy;
    longint    dist_sq;
    bit        clip;
    src_word_t w;
    dx = (longint'(col) << FRAC_BITS) - longint'(shadow_regs.center_x);
    dy = (longint'(row) << FRAC_BITS) - longint'(shadow_regs.center_y);
    dist_sq = dx * dx + dy * dy;
    clip = 1'b0;
    w.col = axis_source(longint'(shadow_regs.center_x), dx,
                        norm_radius_sq(dist_sq, shadow_regs.recip_norm_x), clip);
    w.row = axis_source(longint'(shadow_regs.center_y), dy,
                        norm_radius_sq(dist_sq, shadow_regs.recip_norm_y), clip);
    w.sat = clip;
    return w;
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      2: return 4;
      default: return 8;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pick_coord();
    if ($urandom_range(0, 15) == 0) begin
      return ($urandom_range(0, 1) == 1) ? {IN_W{1'b1}} : {IN_W{1'b0}};
    end
    return IN_W'($urandom());
  endfunction

  function automatic logic [DATA_W-1:0] pick_reg_value(reg_idx_t ri);
    int     style;
    int     k;
    longint d;
    style = $urandom_range(0, 7);
    if (style == 1) begin
      return $urandom();
    end
    case (ri)
      REG_CENTER_X, REG_CENTER_Y: begin
        if (style == 0) begin
          return ($urandom_range(0, 1) == 1) ? 32'h0000_FFFF : 32'h0;
        end
        return 32'($urandom_range(8192, 57344));
      end
      REG_RECIP_NORM_X, REG_RECIP_NORM_Y: begin
        if (style == 0) begin
          return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        d = $urandom_range(512, 4095);
        return 32'((longint'(1) << 40) / (d * d));
      end
      default: begin
        if (style == 0) begin
          case ($urandom_range(0, 2))
            0: return 32'h0007_FFFF;
            1: return 32'hFFF8_0000;
            default: return 32'h0;
          endcase
        end
        if (ri == REG_COEF_ZERO) begin
          k = 65536 + int'($urandom_range(0, 32768)) - 16384;
        end else if (ri == REG_COEF_R2) begin
          k = int'($urandom_range(0, 32768)) - 16384;
        end else begin
          k = int'($urandom_range(0, 8192)) - 4096;
        end
        return 32'(k);
      end
    endcase
  endfunction

  task automatic send_pixel(input logic [IN_W-1:0] col, input logic [IN_W-1:0] row,
                            input bit typed, input src_word_t typed_word);
    int gap;
    if (src_idle_rate != 0 && $urandom_range(1, src_idle_rate) == 1) begin
      gap = $urandom_range(1, 7);
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.pixel_col <= col;
    pix_ch.pixel_row <= row;
    do @(posedge clk); while (!pix_ch.ready);
    if (typed) begin
      pending_src.push_back(typed_word);
    end else begin
      pending_src.push_back(predict_source(col, row));
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_CENTER_X:     shadow_regs.center_x = value[CTR_W-1:0];
      REG_CENTER_Y:     shadow_regs.center_y = value[CTR_W-1:0];
      REG_COEF_ZERO:    shadow_regs.coef_zero = value[COEF_W-1:0];
      REG_COEF_R2:      shadow_regs.coef_r2 = value[COEF_W-1:0];
      REG_COEF_R4:      shadow_regs.coef_r4 = value[COEF_W-1:0];
      REG_RECIP_NORM_X: shadow_regs.recip_norm_x = value;
      REG_RECIP_NORM_Y: shadow_regs.recip_norm_y = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_src.size() != 0) @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    mismatches++;
    $display("%0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && src_ch.valid && src_ch.ready) begin
      if (pending_src.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected source word col=%0d row=%0d sat=%0b", $time,
                 src_ch.source_col, src_ch.source_row, src_ch.saturated);
      end else begin
        want_now = pending_src.pop_front();
        if (src_ch.source_col !== want_now.col) begin
          flag_mismatch("source_col", want_now.col, src_ch.source_col);
        end
        if (src_ch.source_row !== want_now.row) begin
          flag_mismatch("source_row", want_now.row, src_ch.source_row);
        end
        if (src_ch.saturated !== want_now.sat) begin
          flag_mismatch("saturated", {63'd0, want_now.sat}, {63'd0, src_ch.saturated});
        end
      end
    end
  end

  initial begin
    src_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && sink_stall_rate != 0 && $urandom_range(1, sink_stall_rate) == 1) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left != 0) begin
        src_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        src_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL radial_distortion_coordinate_map");
    $finish;
  end

  initial begin
    reg_idx_t  ri;
    src_word_t no_word;
    rst_n            = 1'b0;
    pix_ch.valid     = 1'b0;
    pix_ch.pixel_col = '0;
    pix_ch.pixel_row = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    no_word          = '{20'sd0, 20'sd0, 1'b0};
    shadow_regs      = '0;
    shadow_regs.coef_zero = UNITY_Q16;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    src_idle_rate   = 3;
    sink_stall_rate = 3;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        pix_ch.valid <= 1'b0;
        wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        cfg_ch.valid <= 1'b0;
        send_pixel(directed_rows[i].col, directed_rows[i].row, directed_rows[i].typed,
                   directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pix_ch.valid <= 1'b0;
      wait_drained();
      ri = ri.first();
      do begin
        write_reg(ri, pick_reg_value(ri));
        ri = ri.next();
      end while (ri != ri.first());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, $urandom());
      end
      cfg_ch.valid <= 1'b0;
      if (ph == RAND_PHASES - 1) begin
        src_idle_rate   = 0;
        sink_stall_rate = 0;
      end else begin
        src_idle_rate   = pick_rate();
        sink_stall_rate = pick_rate();
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_pixel(pick_coord(), pick_coord(), 1'b0, no_word);
      end
    end

    pix_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS radial_distortion_coordinate_map");
    end else begin
      $display("FAIL radial_distortion_coordinate_map");
    end
    $finish;
  end

endmodule

>>> radial_distortion_coordinate_map.f
hdl/rdcm_pkg.sv
hdl/rdcm_ifs.sv
hdl/rdcm_cfg_regs.sv
hdl/rdcm_radius.sv
hdl/rdcm_axis.sv
hdl/radial_distortion_coordinate_map.sv
verif/tb_radial_distortion_coordinate_map.sv
